@@ rtl/cpf_pkg.sv @@
// cpf_pkg: shared types and constants for the capture period FIFO.
// Holds the ring depth, item function codes and the front-to-back command.
// No dependencies.
`default_nettype none

package cpf_pkg;

  // Ring geometry: the ring keeps RING_DEPTH-1 periods at most
  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam logic [15:0] NEAR_WRAP  = 16'hFF00;
  localparam logic [31:0] EMPTY_WORD = 32'hFFFFFFFF;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_CAPTURE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  // Memory operation the back end performs for one item
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } mem_op_t;

  // Classified item, front end to back end
  typedef struct packed {
    mem_op_t          op;
    logic [IDX_W-1:0] addr;
    logic [31:0]      period;
    logic             read_empty;
    logic [3:0]       stored_count;
    logic             dropped;
    logic             overflow_taken;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/cpf_front.sv @@
// cpf_front: accepts items, keeps the timestamp and ring index state and
// turns each item into a memory command with its status fields.
// Depends on cpf_pkg.
`default_nettype none

module cpf_front
  import cpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [1:0]  func,
  input  wire logic [15:0] capture_value,
  input  wire logic        overflow_pending,
  output cmd_t             cmd
);

  logic [15:0]      high_word_r, high_word_nxt;
  logic [31:0]      last_ts_r, last_ts_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;

  logic [15:0]      hw_cap;
  logic [31:0]      stamp;
  logic             take_ovf;
  logic [IDX_W-1:0] wr_next, rd_next;
  logic [IDX_W+3:0] count_ext;

  // Ring index advance with wrap at the depth
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  // Capture timestamp: pending overflow counts only away from the wrap point
  assign take_ovf = overflow_pending && (capture_value < NEAR_WRAP);
  assign hw_cap   = high_word_r + {15'd0, take_ovf};
  assign stamp    = {hw_cap, capture_value};
  assign wr_next  = ring_next(wr_idx_r);
  assign rd_next  = ring_next(rd_idx_r);

  // Classify item and compute next state
  always_comb begin
    high_word_nxt = high_word_r;
    last_ts_nxt   = last_ts_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    count_nxt     = count_r;

    cmd.op             = OP_NONE;
    cmd.addr           = wr_next;
    cmd.period         = stamp - last_ts_r;
    cmd.read_empty     = 1'b0;
    cmd.dropped        = 1'b0;
    cmd.overflow_taken = 1'b0;

    case (func_t'(func))
      FUNC_TICK: begin
        high_word_nxt = high_word_r + 16'd1;
      end
      FUNC_CAPTURE: begin
        high_word_nxt      = hw_cap;
        last_ts_nxt        = stamp;
        cmd.overflow_taken = take_ovf;
        if (wr_next != rd_idx_r) begin
          cmd.op     = OP_WRITE;
          wr_idx_nxt = wr_next;
          count_nxt  = count_r + IDX_W'(1);
        end else begin
          cmd.dropped = 1'b1;
        end
      end
      FUNC_READ: begin
        cmd.addr = rd_next;
        if (wr_idx_r == rd_idx_r) begin
          cmd.read_empty = 1'b1;
        end else begin
          cmd.op     = OP_READ;
          rd_idx_nxt = rd_next;
          count_nxt  = count_r - IDX_W'(1);
        end
      end
      FUNC_RESTART: begin
        high_word_nxt = '0;
        last_ts_nxt   = '0;
        wr_idx_nxt    = '0;
        rd_idx_nxt    = '0;
        count_nxt     = '0;
      end
      default: begin
      end
    endcase

    count_ext        = {4'd0, count_nxt};
    cmd.stored_count = count_ext[3:0];
  end

  // State registers, updated on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_word_r <= '0;
      last_ts_r   <= '0;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      count_r     <= '0;
    end else if (take) begin
      high_word_r <= high_word_nxt;
      last_ts_r   <= last_ts_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cpf_queue.sv @@
// cpf_queue: two-entry command queue between front and back ends.
// Depends on cpf_pkg.
`default_nettype none

module cpf_queue
  import cpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      not_full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t       slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;

  assign not_full  = (fill_r != 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head      = slot_r[rptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/cpf_back.sv @@
// cpf_back: executes queued commands on the period memory and holds the
// result register of the output channel.
// Depends on cpf_pkg.
`default_nettype none

module cpf_back
  import cpf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cmd_valid,
  input  wire cmd_t   cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [31:0] out_read_data,
  output logic        out_read_empty,
  output logic [3:0]  out_stored_count,
  output logic        out_dropped,
  output logic        out_overflow_taken
);

  logic [31:0] mem [RING_DEPTH];
  logic [31:0] rd_data_r;
  logic        rd_sel_r;
  logic        valid_r;
  logic        empty_r;
  logic [3:0]  count_r;
  logic        dropped_r;
  logic        taken_r;

  // Load a new command when the result register is free or being drained
  assign cmd_pop = cmd_valid && (!valid_r || out_ready);

  // Period memory: one write or one registered read per command
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd.op == OP_WRITE) begin
        mem[cmd.addr] <= cmd.period;
      end
      rd_data_r <= mem[cmd.addr];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rd_sel_r  <= (cmd.op == OP_READ);
      empty_r   <= cmd.read_empty;
      count_r   <= cmd.stored_count;
      dropped_r <= cmd.dropped;
      taken_r   <= cmd.overflow_taken;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid          = valid_r;
  assign out_read_data      = rd_sel_r ? rd_data_r : EMPTY_WORD;
  assign out_read_empty     = empty_r;
  assign out_stored_count   = count_r;
  assign out_dropped        = dropped_r;
  assign out_overflow_taken = taken_r;

endmodule

`default_nettype wire

@@ rtl/capture_period_fifo.sv @@
// capture_period_fifo: input-capture period measurement with a period ring.
// Instantiates cpf_front, cpf_queue and cpf_back; depends on cpf_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a timer
//   overflow tick, a capture event with its 16-bit count and pending-overflow
//   flag, a read of the oldest period, or a restart.
//   Output channel (out_valid/out_ready) returns exactly one result per item,
//   in order: popped period (all ones when empty or not a read), empty flag,
//   stored period count, drop flag and overflow-taken flag.
//   Result path: each command passes through a queue slot into the result
//   register, which raises out_valid when the output side is free.
//   Throughput: one item per cycle while out_ready stays high; the front end
//   updates its state in the cycle of the transfer and the back end does one
//   memory access per item.
//   A two-entry command queue sits between front and back; when the receiver
//   stalls, the queue and result register absorb up to three items, then
//   in_ready drops until results drain.
//   Reset (rst_n low, synchronous) clears the high word, last timestamp, ring
//   indices, queue and result valid; period memory contents are not cleared
//   and need no clearing pass.
`default_nettype none

module capture_period_fifo
  import cpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_capture_value,
  input  wire logic        in_overflow_pending,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic             out_read_empty,
  output logic [3:0]       out_stored_count,
  output logic             out_dropped,
  output logic             out_overflow_taken
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic take;
  logic q_not_full;
  logic q_not_empty;
  logic q_pop;

  assign in_ready = q_not_full;
  assign take     = in_valid && q_not_full;

  // Front end: classification and index state
  cpf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .func             (in_func),
    .capture_value    (in_capture_value),
    .overflow_pending (in_overflow_pending),
    .cmd              (front_cmd)
  );

  // Command queue
  cpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_cmd  (front_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  // Back end: memory and result register
  cpf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (q_not_empty),
    .cmd                (head_cmd),
    .cmd_pop            (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_read_empty     (out_read_empty),
    .out_stored_count   (out_stored_count),
    .out_dropped        (out_dropped),
    .out_overflow_taken (out_overflow_taken)
  );

endmodule

`default_nettype wire

@@ rtl/cpf_checker.sv @@
// cpf_checker: port-level assertions for capture_period_fifo, bound to the
// top level. Depends on nothing but the top level's ports.
`default_nettype none

module cpf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_func,
  input wire logic [15:0] in_capture_value,
  input wire logic        in_overflow_pending,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_read_data,
  input wire logic        out_read_empty,
  input wire logic [3:0]  out_stored_count,
  input wire logic        out_dropped,
  input wire logic        out_overflow_taken
);

  // No result is shown in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_stored_count) && $stable(out_read_empty))
    else $error("stalled result changed");

  // An empty read returns all ones
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_empty |-> out_read_data == 32'hFFFFFFFF)
    else $error("empty read with data");

  // Capture flags never come with read flags or read data
  a_capture_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_dropped || out_overflow_taken)
      |-> !out_read_empty && out_read_data == 32'hFFFFFFFF)
    else $error("capture flags mixed with read result");

  // A waiting input transfer keeps valid and its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_func)
      && $stable(in_capture_value) && $stable(in_overflow_pending))
    else $error("waiting input changed");

endmodule

bind capture_period_fifo cpf_checker u_cpf_checker (.*);

`default_nettype wire

@@ tb/capture_period_fifo_tb.sv @@
// capture_period_fifo_tb: self-checking testbench for capture_period_fifo.
// Holds a period scoreboard class, the sender and receiver processes and the stimulus.
// Depends on cpf_pkg and the capture_period_fifo RTL.
`timescale 1ns / 100ps

module capture_period_fifo_tb;
  import cpf_pkg::*;

  // One result as the block reports it
  typedef struct {
    logic [31:0] read_data;
    logic        read_empty;
    logic [3:0]  stored_count;
    logic        dropped;
    logic        overflow_taken;
  } period_result_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_SPARSE} rx_mode_t;

  // Item mixes for the random part
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} item_mix_t;

  localparam int RANDOM_ITEMS = 1550;
  localparam int SETTLE_CYCLES = 8;

  // Mirrors the timer extension and the period ring; checks results in order
  class capture_scoreboard;
    logic [15:0]    high_word;
    logic [31:0]    last_stamp;
    logic [31:0]    periods [RING_DEPTH];
    int unsigned    wr_idx;
    int unsigned    rd_idx;
    period_result_t expected_q[$];
    int             err_count;

    function new();
      err_count = 0;
      clear_timer();
    endfunction

    function void clear_timer();
      high_word  = '0;
      last_stamp = '0;
      wr_idx     = 0;
      rd_idx     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("%0t capture_period_fifo_tb: mismatch: %s", $time, msg);
      err_count++;
    endtask

    // Work out the result of one accepted input transfer
    function void note_input(input func_t f, input logic [15:0] cval, input logic pend);
      period_result_t r;
      logic [31:0]    stamp;
      int unsigned    nxt;
      int unsigned    held;
      r.read_data      = EMPTY_WORD;
      r.read_empty     = 1'b0;
      r.dropped        = 1'b0;
      r.overflow_taken = 1'b0;
      case (f)
        FUNC_TICK: begin
          high_word = high_word + 16'd1;
        end
        FUNC_CAPTURE: begin
          // pending overflow only counts well clear of the wrap point
          if (pend && cval < NEAR_WRAP) begin
            high_word = high_word + 16'd1;
            r.overflow_taken = 1'b1;
          end
          stamp = {high_word, cval};
          nxt = (wr_idx + 1) % RING_DEPTH;
          if (nxt != rd_idx) begin
            periods[nxt] = stamp - last_stamp;
            wr_idx = nxt;
          end else begin
            r.dropped = 1'b1;
          end
          last_stamp = stamp;
        end
        FUNC_READ: begin
          if (wr_idx == rd_idx) begin
            r.read_empty = 1'b1;
          end else begin
            nxt = (rd_idx + 1) % RING_DEPTH;
            r.read_data = periods[nxt];
            rd_idx = nxt;
          end
        end
        default: begin
          clear_timer();
        end
      endcase
      held = (wr_idx >= rd_idx) ? wr_idx - rd_idx : RING_DEPTH + wr_idx - rd_idx;
      r.stored_count = held[3:0];
      expected_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    task check_result(input period_result_t got);
      period_result_t want;
      if (expected_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
        if (got.read_empty !== want.read_empty)
          report($sformatf("read_empty %b, want %b", got.read_empty, want.read_empty));
        if (got.stored_count !== want.stored_count)
          report($sformatf("stored_count %0d, want %0d", got.stored_count,
                           want.stored_count));
        if (got.dropped !== want.dropped)
          report($sformatf("dropped %b, want %b", got.dropped, want.dropped));
        if (got.overflow_taken !== want.overflow_taken)
          report($sformatf("overflow_taken %b, want %b", got.overflow_taken,
                           want.overflow_taken));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_TICK;
  logic [15:0] in_capture_value = '0;
  logic        in_overflow_pending = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;
  logic        out_read_empty;
  logic [3:0]  out_stored_count;
  logic        out_dropped;
  logic        out_overflow_taken;

  capture_scoreboard sb;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;

  capture_period_fifo u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_capture_value    (in_capture_value),
    .in_overflow_pending (in_overflow_pending),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_read_empty      (out_read_empty),
    .out_stored_count    (out_stored_count),
    .out_dropped         (out_dropped),
    .out_overflow_taken  (out_overflow_taken)
  );

  always #5 clk = ~clk;

  // Receiver: check each result transfer, then pick ready from the stall pattern
  always @(posedge clk) begin : rx_side
    period_result_t got;
    static rx_mode_t rx_mode = RX_OPEN;
    static int       rx_cycle = 0;
    if (rst_n && out_valid && out_ready) begin
      got.read_data      = out_read_data;
      got.read_empty     = out_read_empty;
      got.stored_count   = out_stored_count;
      got.dropped        = out_dropped;
      got.overflow_taken = out_overflow_taken;
      sb.check_result(got);
    end
    rx_cycle++;
    if (rx_cycle % 150 == 0)
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_LIGHT:  out_ready <= ($urandom_range(0, 99) >= 30);
      RX_HEAVY:  out_ready <= ($urandom_range(0, 99) >= 75);
      default:   out_ready <= (rx_cycle % 5 == 0);
    endcase
  end

  // Drive one item and hold it until the transfer
  task send_item(input func_t f, input logic [15:0] cval, input logic pend);
    in_valid            <= 1'b1;
    in_func             <= f;
    in_capture_value    <= cval;
    in_overflow_pending <= pend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(f, cval, pend);
  endtask

  // Sender in bursts with random gaps between them
  task push_item(input func_t f, input logic [15:0] cval, input logic pend);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_item(f, cval, pend);
  endtask

  // Hold off the sender until every expected result has come back
  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Captured counts: mostly random, often on the wrap threshold or the extremes
  function logic [15:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return NEAR_WRAP - 16'd1 + 16'($urandom_range(0, 2));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random item kind for the given mix
  function func_t pick_func(input item_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 62) return FUNC_CAPTURE;
        if (r < 77) return FUNC_READ;
        if (r < 99) return FUNC_TICK;
      end
      MIX_DRAIN: begin
        if (r < 25) return FUNC_CAPTURE;
        if (r < 80) return FUNC_READ;
        if (r < 97) return FUNC_TICK;
      end
      default: begin
        if (r < 40) return FUNC_CAPTURE;
        if (r < 75) return FUNC_READ;
        if (r < 98) return FUNC_TICK;
      end
    endcase
    return FUNC_RESTART;
  endfunction

  // Main stimulus
  initial begin : stimulus
    int        sent;
    int        seg_len;
    item_mix_t mix;
    func_t     f;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, threshold cases of the pending overflow, negative delta
    push_item(FUNC_READ, 16'h0000, 1'b0);
    push_item(FUNC_CAPTURE, 16'h0100, 1'b0);
    push_item(FUNC_TICK, 16'h0000, 1'b0);
    push_item(FUNC_CAPTURE, 16'h0000, 1'b1);
    push_item(FUNC_CAPTURE, 16'hFEFF, 1'b1);
    push_item(FUNC_CAPTURE, 16'hFF00, 1'b1);
    push_item(FUNC_CAPTURE, 16'hFFFF, 1'b1);
    push_item(FUNC_CAPTURE, 16'h0005, 1'b0);
    push_item(FUNC_RESTART, 16'hFFFF, 1'b1);
    // Fill the ring to the brim; the last capture is dropped
    for (int i = 0; i < RING_DEPTH; i++)
      push_item(FUNC_CAPTURE, 16'(i * 16'h1111), i[0]);
    push_item(FUNC_READ, 16'h0000, 1'b0);
    push_item(FUNC_CAPTURE, 16'hFFFF, 1'b0);
    push_item(FUNC_RESTART, 16'h0000, 1'b0);
    wait_drained();

    // Tick run back to back, then captures on the advanced high word
    gaps_on = 1'b0;
    for (int i = 0; i < 40; i++)
      push_item(FUNC_TICK, 16'(i), i[3]);
    gaps_on = 1'b1;
    push_item(FUNC_CAPTURE, 16'h1234, 1'b0);
    push_item(FUNC_CAPTURE, 16'h0001, 1'b1);
    push_item(FUNC_READ, 16'h0000, 1'b0);
    push_item(FUNC_READ, 16'h0000, 1'b0);
    push_item(FUNC_RESTART, 16'h0000, 1'b0);
    wait_drained();

    // Random segments with changing mixes; now and then let the pipe run dry
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix = item_mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(20, 80);
      for (int i = 0; i < seg_len; i++) begin
        f = pick_func(mix);
        push_item(f, pick_count(), 1'($urandom_range(0, 1)));
        sent++;
      end
      if ($urandom_range(0, 5) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.err_count == 0) begin
      $display("capture_period_fifo_tb: done, clean");
    end else begin
      $display("capture_period_fifo_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("capture_period_fifo_tb: done, errors");
    $finish;
  end

endmodule
